/* rtl/qau_pkg.sv */
// Package of the quaternion arithmetic unit: widths, codes, stage records and helpers.
`timescale 1ns / 1ps
package qau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int RES_BITS  = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int MQ_W      = PROD_W - FRAC_BITS;
  localparam int ACC_W     = MQ_W + 4;
  localparam int SUM_W     = PROD_W + 1;
  localparam int REM_W     = SUM_W + 1;
  localparam int NUM_W     = DATA_W + 2 * FRAC_BITS;
  localparam int Q_BITS    = RES_BITS + 1;
  localparam int SQ_STEPS  = DATA_W;
  localparam int SR_W      = DATA_W + 2;
  localparam int ITER      = (Q_BITS > SQ_STEPS) ? Q_BITS : SQ_STEPS;
  localparam int ROWS      = 3;
  localparam int LANES     = 4;
  localparam int IN_TDATA_W  = 8 * DATA_W;
  localparam int OUT_TDATA_W = 4 * DATA_W;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  localparam acc_t MAXV_A = acc_t'({{(ACC_W-RES_BITS+1){1'b0}}, {(RES_BITS-1){1'b1}}});
  localparam acc_t MINV_A = ~MAXV_A;
  localparam acc_t ONE_A  = acc_t'(1) <<< FRAC_BITS;

  typedef enum logic [2:0] {
    MODE_CONJ   = 3'd0,
    MODE_NORM   = 3'd1,
    MODE_PROD   = 3'd2,
    MODE_ROT    = 3'd3,
    MODE_MATRIX = 3'd4,
    MODE_INV    = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;

  typedef struct packed {
    logic f;
    word_t v;
  } sat_t;

  // Operands and exact first-layer products.
  typedef struct packed {
    logic [2:0] mode;
    word_t w, x, y, z, bx, by, bz;
    prod_t pwbw, pxbx, pyby, pzbz;
    prod_t pbxw, pxbw, pybz, pzby;
    prod_t pbyw, pybw, pzbx, pxbz;
    prod_t pbzw, pzbw, pxby, pybx;
    prod_t pww, pxx, pyy, pzz;
    prod_t pxy, pxz, pyz, pwx, pwy, pwz;
  } s1_t;

  // Saturated first-layer results, squared norm.
  typedef struct packed {
    logic [2:0] mode;
    word_t w, x, y, z, bx, by, bz;
    logic [8:0][DATA_W-1:0] e;
    logic [2:0] g;
    logic [SUM_W-1:0] den;
  } s2_t;

  // Second-layer products for rotation.
  typedef struct packed {
    s2_t b;
    prod_t pwtx, pwty, pwtz;
    prod_t pytz, pzty, pztx, pxtz, pxty, pytx;
  } s3_t;

  // Divider and square-root iteration record.
  typedef struct packed {
    logic [2:0] mode;
    logic [8:0][DATA_W-1:0] e;
    logic [2:0] g;
    logic [SUM_W-1:0] den;
    logic zero;
    logic [LANES-1:0][REM_W-1:0]  rem;
    logic [LANES-1:0][Q_BITS-1:0] nlo;
    logic [LANES-1:0][Q_BITS-1:0] q;
    logic [LANES-1:0] big;
    logic [LANES-1:0] neg;
    logic [SR_W-1:0] srem;
    logic [DATA_W-1:0] root;
    logic [PROD_W-1:0] sbits;
  } it_t;

  // Product floored to FRAC_BITS fraction bits.
  function automatic acc_t mq(input prod_t p);
    return acc_t'(ACC_W'(p >>> FRAC_BITS));
  endfunction

  function automatic acc_t ext(input word_t v);
    return acc_t'(v);
  endfunction

  function automatic sat_t sat(input acc_t v);
    sat_t r;
    r.f = 1'b0;
    if (v > MAXV_A) begin
      r.f = 1'b1;
      r.v = word_t'(MAXV_A[DATA_W-1:0]);
    end else if (v < MINV_A) begin
      r.f = 1'b1;
      r.v = word_t'(MINV_A[DATA_W-1:0]);
    end else begin
      r.v = word_t'(v[DATA_W-1:0]);
    end
    return r;
  endfunction

endpackage

/* rtl/quaternion_arithmetic_unit.sv */
// Quaternion arithmetic unit: conjugate, norm, product, rotation, matrix and inverse.
`timescale 1ns / 1ps
// Usage:
//  Input beats arrive on s_tvalid/s_tready; s_tuser carries the mode, s_tdata the
//  two Q16.16 quaternions (qa_w lowest, qb_z highest). Results leave on
//  m_tvalid/m_tready with res_0..res_3 in m_tdata, status in m_tuser and the
//  final beat of an item flagged by m_tlast.
//  Path from the accepting edge to the first result beat (Q16.16 words throughout):
//  three multiply/add stages, one divide/sqrt setup stage, one
//  stage per quotient bit of the four restoring dividers (the square root runs
//  alongside, two radicand bits a stage), then the output register.
//  Throughput: one input beat per cycle while the receiver does not stall; matrix
//  mode emits three row beats, and the pipeline holds for the two extra beats.
//  Every stage shares one advance enable; when the receiver stalls the whole
//  pipeline holds, and s_tready follows m_tready combinationally.
//  Reset (rst, synchronous) clears all valid bits; the data registers are not reset.
module quaternion_arithmetic_unit
  import qau_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,  // qa_w, qa_x, qa_y, qa_z, qb_w, qb_x, qb_y, qb_z
  input  logic [2:0]             s_tuser,  // mode
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,  // res_0, res_1, res_2, res_3
  output logic [1:0]             m_tuser,  // status
  output logic                   m_tlast
);

  logic adv;

  // ---------------- stage 1: first-layer multipliers
  s1_t s1, s1_next;
  logic v1;

  always_comb begin
    word_t w, x, y, z, bw, bx, by, bz;
    w  = word_t'(s_tdata[1*DATA_W-1:0*DATA_W]);
    x  = word_t'(s_tdata[2*DATA_W-1:1*DATA_W]);
    y  = word_t'(s_tdata[3*DATA_W-1:2*DATA_W]);
    z  = word_t'(s_tdata[4*DATA_W-1:3*DATA_W]);
    bw = word_t'(s_tdata[5*DATA_W-1:4*DATA_W]);
    bx = word_t'(s_tdata[6*DATA_W-1:5*DATA_W]);
    by = word_t'(s_tdata[7*DATA_W-1:6*DATA_W]);
    bz = word_t'(s_tdata[8*DATA_W-1:7*DATA_W]);
    s1_next.mode = s_tuser;
    s1_next.w = w; s1_next.x = x; s1_next.y = y; s1_next.z = z;
    s1_next.bx = bx; s1_next.by = by; s1_next.bz = bz;
    s1_next.pwbw = w * bw;  s1_next.pxbx = x * bx;
    s1_next.pyby = y * by;  s1_next.pzbz = z * bz;
    s1_next.pbxw = bx * w;  s1_next.pxbw = x * bw;
    s1_next.pybz = y * bz;  s1_next.pzby = z * by;
    s1_next.pbyw = by * w;  s1_next.pybw = y * bw;
    s1_next.pzbx = z * bx;  s1_next.pxbz = x * bz;
    s1_next.pbzw = bz * w;  s1_next.pzbw = z * bw;
    s1_next.pxby = x * by;  s1_next.pybx = y * bx;
    s1_next.pww = w * w;    s1_next.pxx = x * x;
    s1_next.pyy = y * y;    s1_next.pzz = z * z;
    s1_next.pxy = x * y;    s1_next.pxz = x * z;
    s1_next.pyz = y * z;    s1_next.pwx = w * x;
    s1_next.pwy = w * y;    s1_next.pwz = w * z;
  end

  // ---------------- stage 2: sums and saturation
  s2_t s2, s2_next;
  logic v2;

  always_comb begin
    acc_t av [9];
    sat_t sr [9];
    logic [8:0] f;
    for (int k = 0; k < 9; k++) av[k] = '0;
    s2_next.mode = s1.mode;
    s2_next.w = s1.w; s2_next.x = s1.x; s2_next.y = s1.y; s2_next.z = s1.z;
    s2_next.bx = s1.bx; s2_next.by = s1.by; s2_next.bz = s1.bz;
    s2_next.den = {1'b0, s1.pww} + {1'b0, s1.pxx} + {1'b0, s1.pyy} + {1'b0, s1.pzz};
    unique case (s1.mode)
      MODE_CONJ: begin
        av[0] = ext(s1.w);
        av[1] = -ext(s1.x);
        av[2] = -ext(s1.y);
        av[3] = -ext(s1.z);
      end
      MODE_PROD: begin
        av[0] = mq(s1.pwbw) - mq(s1.pxbx) - mq(s1.pyby) - mq(s1.pzbz);
        av[1] = mq(s1.pbxw) + mq(s1.pxbw) + mq(s1.pybz) - mq(s1.pzby);
        av[2] = mq(s1.pbyw) + mq(s1.pybw) + mq(s1.pzbx) - mq(s1.pxbz);
        av[3] = mq(s1.pbzw) + mq(s1.pzbw) + mq(s1.pxby) - mq(s1.pybx);
      end
      MODE_ROT: begin
        // t = a.v x b.v
        av[0] = mq(s1.pybz) - mq(s1.pzby);
        av[1] = mq(s1.pzbx) - mq(s1.pxbz);
        av[2] = mq(s1.pxby) - mq(s1.pybx);
      end
      MODE_MATRIX: begin
        av[0] = ONE_A - (mq(s1.pyy) <<< 1) - (mq(s1.pzz) <<< 1);
        av[1] = (mq(s1.pxy) <<< 1) - (mq(s1.pwz) <<< 1);
        av[2] = (mq(s1.pxz) <<< 1) + (mq(s1.pwy) <<< 1);
        av[3] = (mq(s1.pxy) <<< 1) + (mq(s1.pwz) <<< 1);
        av[4] = ONE_A - (mq(s1.pxx) <<< 1) - (mq(s1.pzz) <<< 1);
        av[5] = (mq(s1.pyz) <<< 1) - (mq(s1.pwx) <<< 1);
        av[6] = (mq(s1.pxz) <<< 1) - (mq(s1.pwy) <<< 1);
        av[7] = (mq(s1.pyz) <<< 1) + (mq(s1.pwx) <<< 1);
        av[8] = ONE_A - (mq(s1.pxx) <<< 1) - (mq(s1.pyy) <<< 1);
      end
      default: begin
      end
    endcase
    for (int k = 0; k < 9; k++) begin
      sr[k] = sat(av[k]);
      f[k] = sr[k].f;
      s2_next.e[k] = sr[k].v;
    end
    if (s1.mode == MODE_MATRIX) begin
      s2_next.g = {|f[8:6], |f[5:3], |f[2:0]};
    end else begin
      s2_next.g = {2'b00, |f[3:0]};
    end
  end

  // ---------------- stage 3: second-layer multipliers (rotation)
  s3_t s3, s3_next;
  logic v3;

  always_comb begin
    word_t tx, ty, tz;
    tx = word_t'(s2.e[0]);
    ty = word_t'(s2.e[1]);
    tz = word_t'(s2.e[2]);
    s3_next.b = s2;
    s3_next.pwtx = s2.w * tx;  s3_next.pwty = s2.w * ty;  s3_next.pwtz = s2.w * tz;
    s3_next.pytz = s2.y * tz;  s3_next.pzty = s2.z * ty;
    s3_next.pztx = s2.z * tx;  s3_next.pxtz = s2.x * tz;
    s3_next.pxty = s2.x * ty;  s3_next.pytx = s2.y * tx;
  end

  // ---------------- stage 4: rotation sums, divider and sqrt setup
  it_t it [ITER+1];
  logic [ITER:0] itv;
  it_t it0_next;

  always_comb begin
    acc_t ra [3];
    sat_t rs [3];
    word_t cw [LANES];
    logic signed [DATA_W:0] cv;
    logic [DATA_W-1:0] cm;
    logic [NUM_W-1:0] nn;
    logic [REM_W-1:0] r0;
    ra[0] = ext(s3.b.bx) + (mq(s3.pwtx) <<< 1) + ((mq(s3.pytz) - mq(s3.pzty)) <<< 1);
    ra[1] = ext(s3.b.by) + (mq(s3.pwty) <<< 1) + ((mq(s3.pztx) - mq(s3.pxtz)) <<< 1);
    ra[2] = ext(s3.b.bz) + (mq(s3.pwtz) <<< 1) + ((mq(s3.pxty) - mq(s3.pytx)) <<< 1);
    for (int k = 0; k < 3; k++) rs[k] = sat(ra[k]);
    it0_next.mode = s3.b.mode;
    it0_next.e = s3.b.e;
    it0_next.g = s3.b.g;
    if (s3.b.mode == MODE_ROT) begin
      it0_next.e[0] = rs[0].v;
      it0_next.e[1] = rs[1].v;
      it0_next.e[2] = rs[2].v;
      it0_next.e[3] = '0;
      it0_next.g[0] = s3.b.g[0] | rs[0].f | rs[1].f | rs[2].f;
    end
    it0_next.den = s3.b.den;
    it0_next.zero = (s3.b.den == '0);
    // conjugate components: w, -x, -y, -z
    cw[0] = s3.b.w; cw[1] = s3.b.x; cw[2] = s3.b.y; cw[3] = s3.b.z;
    for (int l = 0; l < LANES; l++) begin
      cv = $signed({cw[l][DATA_W-1], cw[l]});
      if (l != 0) cv = -cv;
      it0_next.neg[l] = cv[DATA_W];
      cm = cv[DATA_W] ? DATA_W'(-cv) : DATA_W'(cv);
      nn = {cm, {(2*FRAC_BITS){1'b0}}};
      r0 = REM_W'(nn[NUM_W-1:Q_BITS]);
      it0_next.rem[l] = r0;
      it0_next.big[l] = (r0 >= {1'b0, s3.b.den});
      it0_next.nlo[l] = nn[Q_BITS-1:0];
      it0_next.q[l] = '0;
    end
    it0_next.srem = '0;
    it0_next.root = '0;
    it0_next.sbits = s3.b.den[PROD_W-1:0];
  end

  // ---------------- iteration stages: one quotient bit each, one root bit in each of the first SQ_STEPS
  for (genvar gi = 0; gi < ITER; gi++) begin : g_iter
    it_t nx;
    always_comb begin
      logic [REM_W-1:0] t;
      logic [SR_W-1:0] st, tr;
      logic qb;
      nx = it[gi];
      if (gi < Q_BITS) begin
        for (int l = 0; l < LANES; l++) begin
          t = {it[gi].rem[l][REM_W-2:0], it[gi].nlo[l][Q_BITS-1]};
          qb = (t >= {1'b0, it[gi].den});
          nx.rem[l] = qb ? (t - {1'b0, it[gi].den}) : t;
          nx.q[l] = {it[gi].q[l][Q_BITS-2:0], qb};
          nx.nlo[l] = it[gi].nlo[l] << 1;
        end
      end
      if (gi < SQ_STEPS) begin
        st = {it[gi].srem[SR_W-3:0], it[gi].sbits[PROD_W-1:PROD_W-2]};
        tr = {it[gi].root, 2'b01};
        if (st >= tr) begin
          nx.srem = st - tr;
          nx.root = {it[gi].root[DATA_W-2:0], 1'b1};
        end else begin
          nx.srem = st;
          nx.root = {it[gi].root[DATA_W-2:0], 1'b0};
        end
        nx.sbits = it[gi].sbits << 2;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) it[gi+1] <= nx;
    end
  end

  // ---------------- final results into the output register
  logic [8:0][DATA_W-1:0] fv;
  word_t fz;
  logic [2:0][1:0] fst;
  logic fmulti;

  always_comb begin
    sat_t ns, ls;
    acc_t qa;
    logic anyf;
    word_t lv [LANES];
    fv = it[ITER].e;
    fz = word_t'(it[ITER].e[3]);
    fst = {ST_OK, ST_OK, (it[ITER].g[0] ? ST_SAT : ST_OK)};
    fmulti = 1'b0;
    anyf = 1'b0;
    ns = sat(acc_t'({1'b0, it[ITER].root}));
    for (int l = 0; l < LANES; l++) begin
      qa = acc_t'({1'b0, it[ITER].q[l]});
      ls = sat(it[ITER].neg[l] ? -qa : qa);
      if (it[ITER].big[l]) begin
        ls.f = 1'b1;
        ls.v = it[ITER].neg[l] ? word_t'(MINV_A[DATA_W-1:0]) : word_t'(MAXV_A[DATA_W-1:0]);
      end
      lv[l] = ls.v;
      anyf = anyf | ls.f;
    end
    unique case (it[ITER].mode)
      MODE_MATRIX: begin
        fmulti = 1'b1;
        fz = '0;
        for (int k = 0; k < ROWS; k++) fst[k] = it[ITER].g[k] ? ST_SAT : ST_OK;
      end
      MODE_NORM: begin
        fv = '0;
        fz = '0;
        if (it[ITER].den[SUM_W-1]) begin
          // sum of squares beyond 64 bits: root is far past the range
          fv[0] = MAXV_A[DATA_W-1:0];
          fst[0] = ST_SAT;
        end else begin
          fv[0] = ns.v;
          fst[0] = ns.f ? ST_SAT : ST_OK;
        end
      end
      MODE_INV: begin
        fv = '0;
        fz = '0;
        if (it[ITER].zero) begin
          fst[0] = ST_DIV0;
        end else begin
          fv[0] = lv[0];
          fv[1] = lv[1];
          fv[2] = lv[2];
          fz = lv[3];
          fst[0] = anyf ? ST_SAT : ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------- output register, shifts out matrix rows
  logic ser_valid, ser_multi, ser_last;
  logic [1:0] ser_cnt;
  logic [8:0][DATA_W-1:0] ser_v;
  word_t ser_z;
  logic [2:0][1:0] ser_st;

  assign ser_last = !ser_multi || (ser_cnt == 2'(ROWS - 1));
  assign adv = !ser_valid || (m_tready && ser_last);
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      itv <= '0;
      ser_valid <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      itv <= {itv[ITER-1:0], v3};
      ser_valid <= itv[ITER];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s3_next;
      it[0] <= it0_next;
      ser_v <= fv;
      ser_z <= fz;
      ser_st <= fst;
      ser_multi <= fmulti;
      ser_cnt <= '0;
    end else if (m_tready && ser_valid) begin
      // next matrix row beat
      ser_v <= {{(3*DATA_W){1'b0}}, ser_v[8:3]};
      ser_st <= {2'b00, ser_st[2:1]};
      ser_cnt <= ser_cnt + 2'd1;
    end
  end

  assign m_tvalid = ser_valid;
  assign m_tdata  = {ser_z, ser_v[2], ser_v[1], ser_v[0]};
  assign m_tuser  = ser_st[0];
  assign m_tlast  = ser_last;

endmodule

/* bench/testbench.sv */
// Self-checking bench for the quaternion arithmetic unit: directed table, then random beats.
`timescale 1ns / 1ps
module testbench;
  import qau_pkg::*;

  localparam logic [2:0] MODE_UNUSED6 = 3'd6;
  localparam logic [2:0] MODE_UNUSED7 = 3'd7;
  localparam longint     WMAX = 64'sd2147483647;
  localparam longint     WMIN = -64'sd2147483648;
  localparam logic [31:0] ONE_Q = 32'h0001_0000;
  localparam int         STALL_LIMIT = 20000;
  localparam int         DRAIN_CYCLES = 80;

  typedef logic [3:0][31:0] quat_t;

  typedef struct packed {
    logic [31:0] r3, r2, r1, r0;
    logic [1:0]  st;
    logic        lst;
  } beat_t;

  typedef struct packed {
    logic [2:0] mode;
    quat_t      qa, qb;
    logic       typed;
    beat_t      want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [1:0] m_tuser;
  logic m_tlast;

  beat_t pending_q[$];
  row_t  stim_table[$];
  int    mismatches = 0;
  int    idle_pct = 0;
  int    stall_pct = 0;
  int    quiet_cycles = 0;
  bit    next_typed = 1'b0;
  beat_t next_want;

  always #1 clk = ~clk;

  quaternion_arithmetic_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  // ---------------- predictor ----------------
  function automatic longint fmul(longint p, longint q);
    longint t;
    t = p * q;
    return t >>> FRAC_BITS;
  endfunction

  function automatic logic [31:0] clamp(longint v, inout bit flag);
    if (v > WMAX) begin
      flag = 1'b1;
      return WMAX[31:0];
    end
    if (v < WMIN) begin
      flag = 1'b1;
      return WMIN[31:0];
    end
    return v[31:0];
  endfunction

  function automatic longint unsigned magn(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // Expected result beats for one input beat, appended to pending_q.
  function automatic void quat_predict(logic [2:0] mode, quat_t qa, quat_t qb);
    longint w, x, y, z, bw, bx, by, bz, tx, ty, tz;
    longint m[9];
    longint c[4];
    logic [65:0] sumsq, sq, trial;
    logic [95:0] num, quo;
    longint unsigned root;
    bit f, g;
    beat_t o;
    w = longint'($signed(qa[0])); x = longint'($signed(qa[1]));
    y = longint'($signed(qa[2])); z = longint'($signed(qa[3]));
    bw = longint'($signed(qb[0])); bx = longint'($signed(qb[1]));
    by = longint'($signed(qb[2])); bz = longint'($signed(qb[3]));
    f = 1'b0;
    o = '0;
    o.lst = 1'b1;
    case (mode)
      MODE_CONJ: begin
        o.r0 = clamp(w, f); o.r1 = clamp(-x, f);
        o.r2 = clamp(-y, f); o.r3 = clamp(-z, f);
      end
      MODE_NORM, MODE_INV: begin
        sumsq = 66'(magn(w) * magn(w)) + 66'(magn(x) * magn(x))
              + 66'(magn(y) * magn(y)) + 66'(magn(z) * magn(z));
        if (mode == MODE_NORM) begin
          if (sumsq[65:64] != 0) begin
            f = 1'b1;
            o.r0 = WMAX[31:0];
          end else begin
            root = 0;
            for (int i = 31; i >= 0; i--) begin
              trial = 66'(root | (64'd1 << i));
              sq = trial * trial;
              if (sq <= sumsq) root = trial[63:0];
            end
            o.r0 = clamp(longint'(root), f);
          end
        end else if (sumsq == 0) begin
          o.st = ST_DIV0;
        end else begin
          c[0] = w; c[1] = -x; c[2] = -y; c[3] = -z;
          for (int j = 0; j < 4; j++) begin
            num = 96'(magn(c[j])) << (2 * FRAC_BITS);
            quo = num / 96'(sumsq);
            if (quo >= (96'd1 << 40)) quo = 96'd1 << 40;
            if (j == 0) o.r0 = clamp(c[j] < 0 ? -longint'(quo) : longint'(quo), f);
            if (j == 1) o.r1 = clamp(c[j] < 0 ? -longint'(quo) : longint'(quo), f);
            if (j == 2) o.r2 = clamp(c[j] < 0 ? -longint'(quo) : longint'(quo), f);
            if (j == 3) o.r3 = clamp(c[j] < 0 ? -longint'(quo) : longint'(quo), f);
          end
        end
      end
      MODE_PROD: begin
        o.r0 = clamp(fmul(w, bw) - fmul(x, bx) - fmul(y, by) - fmul(z, bz), f);
        o.r1 = clamp(fmul(bx, w) + fmul(x, bw) + fmul(y, bz) - fmul(z, by), f);
        o.r2 = clamp(fmul(by, w) + fmul(y, bw) + fmul(z, bx) - fmul(x, bz), f);
        o.r3 = clamp(fmul(bz, w) + fmul(z, bw) + fmul(x, by) - fmul(y, bx), f);
      end
      MODE_ROT: begin
        // t = a.v x b.v, clamped before the second layer
        tx = longint'($signed(clamp(fmul(y, bz) - fmul(z, by), f)));
        ty = longint'($signed(clamp(fmul(z, bx) - fmul(x, bz), f)));
        tz = longint'($signed(clamp(fmul(x, by) - fmul(y, bx), f)));
        o.r0 = clamp(bx + 2 * fmul(w, tx) + 2 * (fmul(y, tz) - fmul(z, ty)), f);
        o.r1 = clamp(by + 2 * fmul(w, ty) + 2 * (fmul(z, tx) - fmul(x, tz)), f);
        o.r2 = clamp(bz + 2 * fmul(w, tz) + 2 * (fmul(x, ty) - fmul(y, tx)), f);
      end
      MODE_MATRIX: begin
        m[0] = (1 <<< FRAC_BITS) - 2 * fmul(y, y) - 2 * fmul(z, z);
        m[1] = 2 * fmul(x, y) - 2 * fmul(w, z);
        m[2] = 2 * fmul(x, z) + 2 * fmul(w, y);
        m[3] = 2 * fmul(x, y) + 2 * fmul(w, z);
        m[4] = (1 <<< FRAC_BITS) - 2 * fmul(x, x) - 2 * fmul(z, z);
        m[5] = 2 * fmul(y, z) - 2 * fmul(w, x);
        m[6] = 2 * fmul(x, z) - 2 * fmul(w, y);
        m[7] = 2 * fmul(y, z) + 2 * fmul(w, x);
        m[8] = (1 <<< FRAC_BITS) - 2 * fmul(x, x) - 2 * fmul(y, y);
        for (int k = 0; k < 3; k++) begin
          g = 1'b0;
          o = '0;
          o.r0 = clamp(m[3 * k], g);
          o.r1 = clamp(m[3 * k + 1], g);
          o.r2 = clamp(m[3 * k + 2], g);
          o.st = g ? ST_SAT : ST_OK;
          o.lst = (k == 2);
          pending_q.push_back(o);
        end
        return;
      end
      default: ;  // unused modes: one all-zero beat
    endcase
    if (o.st == ST_OK && f) o.st = ST_SAT;
    pending_q.push_back(o);
  endfunction

  // ---------------- input and output monitors ----------------
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        if (next_typed) pending_q.push_back(next_want);
        else quat_predict(s_tuser, s_tdata[127:0], s_tdata[255:128]);
      end
      if (m_tvalid && m_tready) begin
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", m_tdata);
        end else begin
          beat_t e;
          e = pending_q.pop_front();
          if (m_tdata[31:0] !== e.r0 || m_tdata[63:32] !== e.r1 ||
              m_tdata[95:64] !== e.r2 || m_tdata[127:96] !== e.r3 ||
              m_tuser !== e.st || m_tlast !== e.lst) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h %h %h %h st %0d last %0d, got %h %h %h %h st %0d last %0d",
                       e.r0, e.r1, e.r2, e.r3, e.st, e.lst,
                       m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96],
                       m_tuser, m_tlast);
          end
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  // watchdog: cycles without any beat moving
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2, 3: return $urandom;
      default: return 32'($signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000);
    endcase
  endfunction

  task automatic send_beat(logic [2:0] mode, quat_t qa, quat_t qb, bit typed, beat_t want);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid   <= 1'b1;
    s_tuser    <= mode;
    s_tdata    <= {qb, qa};
    next_typed <= typed;
    next_want  <= want;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic add_row(logic [2:0] mode, quat_t qa, quat_t qb, bit typed, beat_t want);
    row_t r;
    r.mode = mode; r.qa = qa; r.qb = qb; r.typed = typed; r.want = want;
    stim_table.push_back(r);
  endtask

  initial begin
    beat_t zero_b, b;
    quat_t qa, qb, ident, maxq, minq;
    logic [2:0] mode;
    zero_b = '0;
    zero_b.lst = 1'b1;
    ident = {32'd0, 32'd0, 32'd0, ONE_Q};
    maxq = {4{32'h7fff_ffff}};
    minq = {4{32'h8000_0000}};

    // directed table: typed expectations only where obvious
    add_row(MODE_CONJ, '0, '0, 1'b1, zero_b);
    add_row(MODE_CONJ, {32'h0003_0000, 32'hfffe_0000, 32'h0001_8000, ONE_Q}, '0, 1'b0, zero_b);
    add_row(MODE_CONJ, minq, '0, 1'b0, zero_b);
    add_row(MODE_CONJ, maxq, maxq, 1'b0, zero_b);
    b = zero_b; b.r0 = ONE_Q;
    add_row(MODE_NORM, ident, '0, 1'b1, b);
    b = zero_b; b.r0 = WMAX[31:0]; b.st = ST_SAT;
    add_row(MODE_NORM, minq, '0, 1'b1, b);            // squared norm overflows 64 bits
    add_row(MODE_NORM, maxq, '0, 1'b0, zero_b);
    add_row(MODE_NORM, {32'h0, 32'h0, 32'h0, 32'h0000_0003}, '0, 1'b0, zero_b);
    add_row(MODE_PROD, ident, {32'h1234_5678, 32'hfedc_ba98, 32'h0002_0000, 32'h8000_0000},
            1'b0, zero_b);
    add_row(MODE_PROD, maxq, minq, 1'b0, zero_b);
    add_row(MODE_PROD, minq, minq, 1'b0, zero_b);
    add_row(MODE_ROT, ident, {32'h0003_0000, 32'h0002_0000, 32'h0001_0000, 32'h0}, 1'b0, zero_b);
    add_row(MODE_ROT, {32'h0, 32'h0, 32'h0000_b505, 32'h0000_b505},
            {32'h0, 32'h0, 32'h0, ONE_Q}, 1'b0, zero_b);
    add_row(MODE_ROT, maxq, minq, 1'b0, zero_b);
    add_row(MODE_MATRIX, ident, '0, 1'b0, zero_b);
    add_row(MODE_MATRIX, {32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000}, '0,
            1'b0, zero_b);
    add_row(MODE_MATRIX, minq, '0, 1'b0, zero_b);
    add_row(MODE_MATRIX, maxq, '0, 1'b0, zero_b);
    b = zero_b; b.st = ST_DIV0;
    add_row(MODE_INV, '0, '0, 1'b1, b);               // zero norm
    b = zero_b; b.r0 = ONE_Q;
    add_row(MODE_INV, ident, '0, 1'b1, b);
    add_row(MODE_INV, {32'h0, 32'h0, 32'h0000_0001, 32'h0}, '0, 1'b0, zero_b);
    add_row(MODE_INV, minq, '0, 1'b0, zero_b);
    add_row(MODE_INV, {32'hffff_0000, 32'h0002_0000, 32'h0, 32'h0003_0000}, '0, 1'b0, zero_b);
    add_row(MODE_UNUSED6, maxq, maxq, 1'b1, zero_b);
    add_row(MODE_UNUSED7, minq, minq, 1'b1, zero_b);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_table[i])
      send_beat(stim_table[i].mode, stim_table[i].qa, stim_table[i].qb,
                stim_table[i].typed, stim_table[i].want);

    // random part in four idling phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 69; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      for (int n = 0; n < 125; n++) begin
        // mostly valid modes, an occasional unused code
        mode = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
        for (int j = 0; j < 4; j++) begin
          qa[j] = pick_word();
          qb[j] = pick_word();
        end
        send_beat(mode, qa, qb, 1'b0, zero_b);
      end
    end
    s_tvalid <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/qau_pkg.sv
rtl/quaternion_arithmetic_unit.sv
bench/testbench.sv
